// ===== design/dsv_pkg.sv =====
// Package of types and constants shared by the date string validator files.
`timescale 1ns / 1ps
package dsv_pkg;

   localparam int CHAR_W     = 8;
   localparam int YEAR_W     = 14;
   localparam int FIELD_W    = 7;
   localparam int POS_W      = 4;
   localparam int DIGIT_W    = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [POS_W-1:0] POS_DASH_YEAR  = 4'd4;
   localparam logic [POS_W-1:0] POS_DASH_MONTH = 4'd7;
   localparam logic [POS_W-1:0] POS_LAST       = 4'd9;
   localparam logic [POS_W-1:0] POS_LENGTH     = 4'd10;
   localparam logic [POS_W-1:0] POS_SATURATE   = 4'd11;
   localparam logic [POS_W-1:0] POS_CENTURY    = 4'd1;
   localparam logic [POS_W-1:0] POS_YEAR_TENS  = 4'd2;
   localparam logic [POS_W-1:0] POS_YEAR_UNITS = 4'd3;

   localparam logic [CHAR_W-1:0] ASCII_DASH = 8'h2D;
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;

   localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 14'd1970;
   localparam logic [YEAR_W-1:0] MAX_YEAR_RESET = 14'd3000;

   localparam logic [FIELD_W-1:0] MONTH_FEB  = 7'd2;
   localparam logic [FIELD_W-1:0] MONTH_APR  = 7'd4;
   localparam logic [FIELD_W-1:0] MONTH_JUN  = 7'd6;
   localparam logic [FIELD_W-1:0] MONTH_SEP  = 7'd9;
   localparam logic [FIELD_W-1:0] MONTH_NOV  = 7'd11;
   localparam logic [FIELD_W-1:0] MONTH_MAX  = 7'd12;
   localparam logic [FIELD_W-1:0] DAY_MAX    = 7'd31;
   localparam logic [FIELD_W-1:0] DAY_SHORT  = 7'd30;
   localparam logic [FIELD_W-1:0] DAY_FEB    = 7'd29;

   typedef enum logic {
      CSR_MIN_YEAR = 1'b0,
      CSR_MAX_YEAR = 1'b1
   } csr_index_type;

endpackage

// ===== design/dsv_req_if.sv =====
// Request channel interface carrying one character of the date text.
`timescale 1ns / 1ps
interface dsv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_final;

   modport source (output valid, output char_code, output is_final, input ready);
   modport sink (input valid, input char_code, input is_final, output ready);
endinterface

// ===== design/dsv_rsp_if.sv =====
// Response channel interface carrying the verdict on one date text.
`timescale 1ns / 1ps
interface dsv_rsp_if;
   logic valid;
   logic ready;
   logic date_valid;

   modport source (output valid, output date_valid, input ready);
   modport sink (input valid, input date_valid, output ready);
endinterface

// ===== design/date_string_validator_unit.sv =====
// Top level of the date string validator: checks YYYY-MM-DD texts character by character.
`timescale 1ns / 1ps
// Characters of a date text arrive on the request channel, one per transaction,
// with is_final set on the last one. Every character is checked and folded into
// the running year, month and day values in the cycle it is accepted, so a new
// character can be taken in every clock cycle unless a stalled response holds it off.
// The final character produces one response transaction in the cycle after it is
// accepted; date_valid is high only for a well formed ten character calendar date
// whose year lies within the bounds held in the min_year and max_year registers.
// Other characters produce no response.
// The response sits in an output register. While it waits, the block still
// takes a character in the cycle the receiver takes the response; if the
// receiver stalls, the request channel is held off until the response goes.
// Synchronous reset clears the text state, empties the output register and
// restores the year bounds to 1970 and 3000. The registers are written over the
// APB-style port at byte addresses 0 and 4 and should only be changed while idle.
module date_string_validator_unit (
   input  logic                             clock,
   input  logic                             reset,
   dsv_req_if.sink                          req_chan,
   dsv_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dsv_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dsv_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dsv_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import dsv_pkg::*;

   logic [YEAR_W-1:0]  min_year_ff, max_year_ff;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [FIELD_W-1:0] month_ff, month_in;
   logic [FIELD_W-1:0] day_ff, day_in;
   logic               fmt_err_ff, fmt_err_in;
   logic [1:0]         year_mod4_ff, year_mod4_in;
   logic [1:0]         cent_mod4_ff, cent_mod4_in;
   logic               low_zero_ff, low_zero_in;
   logic               rsp_valid_ff;
   logic               date_valid_ff, date_valid_in;

   logic               req_fire, csr_write;
   logic               is_digit;
   logic [DIGIT_W-1:0] digit;
   logic [CHAR_W-1:0]  char_off;
   logic               leap, month_ok, day_ok, year_ok, short_ok, feb_ok;
   csr_index_type      csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_comb begin
      unique case (csr_index)
         CSR_MIN_YEAR: csr_prdata = {{(CSR_DATA_W-YEAR_W){1'b0}}, min_year_ff};
         CSR_MAX_YEAR: csr_prdata = {{(CSR_DATA_W-YEAR_W){1'b0}}, max_year_ff};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_year_ff <= MIN_YEAR_RESET;
         max_year_ff <= MAX_YEAR_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MIN_YEAR: min_year_ff <= csr_pwdata[YEAR_W-1:0];
            CSR_MAX_YEAR: max_year_ff <= csr_pwdata[YEAR_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign char_off = req_chan.char_code - ASCII_ZERO;
   assign is_digit = (req_chan.char_code >= ASCII_ZERO) && (req_chan.char_code <= ASCII_NINE);
   assign digit    = is_digit ? char_off[DIGIT_W-1:0] : '0;

   always_comb begin
      fmt_err_in   = fmt_err_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      year_mod4_in = year_mod4_ff;
      cent_mod4_in = cent_mod4_ff;
      low_zero_in  = low_zero_ff;

      if (pos_ff >= POS_LENGTH) begin
         fmt_err_in = 1'b1;
      end else if (pos_ff == POS_DASH_YEAR || pos_ff == POS_DASH_MONTH) begin
         if (req_chan.char_code != ASCII_DASH) begin
            fmt_err_in = 1'b1;
         end
      end else if (!is_digit) begin
         fmt_err_in = 1'b1;
      end else if (pos_ff < POS_DASH_YEAR) begin
         year_in      = (year_ff << 3) + (year_ff << 1) + YEAR_W'(digit);
         // Ten is two modulo four, so the residue follows from the old one.
         year_mod4_in = {year_mod4_ff[0], 1'b0} + digit[1:0];
         if (pos_ff == POS_CENTURY) begin
            cent_mod4_in = {year_mod4_ff[0], 1'b0} + digit[1:0];
         end
         if (pos_ff == POS_YEAR_TENS) begin
            low_zero_in = (digit == '0);
         end else if (pos_ff == POS_YEAR_UNITS) begin
            low_zero_in = low_zero_ff && (digit == '0);
         end
      end else if (pos_ff < POS_DASH_MONTH) begin
         month_in = (month_ff << 3) + (month_ff << 1) + FIELD_W'(digit);
      end else begin
         day_in = (day_ff << 3) + (day_ff << 1) + FIELD_W'(digit);
      end

      pos_in = (pos_ff < POS_SATURATE) ? pos_ff + 1'b1 : pos_ff;
   end

   // A year is a leap year when divisible by four, unless it closes a century
   // whose number is not itself divisible by four.
   assign leap     = (year_mod4_ff == 2'd0) && (!low_zero_ff || cent_mod4_ff == 2'd0);
   assign month_ok = (month_in >= 7'd1) && (month_in <= MONTH_MAX);
   assign day_ok   = (day_in >= 7'd1) && (day_in <= DAY_MAX);
   assign year_ok  = (year_ff >= min_year_ff) && (year_ff <= max_year_ff);
   assign short_ok = !((month_in == MONTH_APR || month_in == MONTH_JUN ||
                        month_in == MONTH_SEP || month_in == MONTH_NOV) &&
                       day_in > DAY_SHORT);
   assign feb_ok   = (month_in != MONTH_FEB) ||
                     ((day_in < DAY_FEB) || (day_in == DAY_FEB && leap));

   assign date_valid_in = !fmt_err_in && (pos_ff == POS_LAST) && month_ok && day_ok &&
                          year_ok && short_ok && feb_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         year_ff      <= '0;
         month_ff     <= '0;
         day_ff       <= '0;
         fmt_err_ff   <= 1'b0;
         year_mod4_ff <= '0;
         cent_mod4_ff <= '0;
         low_zero_ff  <= 1'b0;
      end else if (req_fire) begin
         if (req_chan.is_final) begin
            pos_ff       <= '0;
            year_ff      <= '0;
            month_ff     <= '0;
            day_ff       <= '0;
            fmt_err_ff   <= 1'b0;
            year_mod4_ff <= '0;
            cent_mod4_ff <= '0;
            low_zero_ff  <= 1'b0;
         end else begin
            pos_ff       <= pos_in;
            year_ff      <= year_in;
            month_ff     <= month_in;
            day_ff       <= day_in;
            fmt_err_ff   <= fmt_err_in;
            year_mod4_ff <= year_mod4_in;
            cent_mod4_ff <= cent_mod4_in;
            low_zero_ff  <= low_zero_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && req_chan.is_final) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_chan.is_final) begin
         date_valid_ff <= date_valid_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.date_valid = date_valid_ff;

endmodule
